### design/i2cmes_pkg.sv
`default_nettype none

package i2cmes_pkg;

    // Status word bit positions
    localparam int unsigned F_SB   = 0;
    localparam int unsigned F_ADDR = 1;
    localparam int unsigned F_BTF  = 2;
    localparam int unsigned F_RXNE = 6;
    localparam int unsigned F_TXE  = 7;
    localparam int unsigned F_BERR = 8;
    localparam int unsigned F_ARLO = 9;
    localparam int unsigned F_AF   = 10;
    localparam int unsigned F_OVR  = 11;

    localparam int unsigned STATUS_W = 12;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned BYTE_W   = 8;

    // Direction bit of the address byte: read sets it
    localparam logic DIR_READ  = 1'b1;
    localparam logic DIR_WRITE = 1'b0;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_EVENT = 2'd2,
        REQ_ERROR = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_READY = 2'd0,
        ST_TX    = 2'd1,
        ST_RX    = 2'd2,
        ST_ERROR = 2'd3
    } t_ctrl_state;

    typedef enum logic [2:0] {
        ERR_NONE = 3'd0,
        ERR_BUSY = 3'd1,
        ERR_SB   = 3'd2,
        ERR_AF   = 3'd3,
        ERR_BUS  = 3'd4,
        ERR_ARLO = 3'd5,
        ERR_OVR  = 3'd6
    } t_err;

    typedef enum logic [1:0] {
        ACK_KEEP = 2'd0,
        ACK_ON   = 2'd1,
        ACK_OFF  = 2'd2
    } t_ack;

    typedef struct packed {
        t_req                  req_type;
        logic [BYTE_W-1:0]     dev_addr;
        logic [LEN_W-1:0]      xfer_len;
        logic                  bus_busy;
        logic [STATUS_W-1:0]   status;
        logic [BYTE_W-1:0]     tx_byte;
        logic [BYTE_W-1:0]     rx_byte;
    } t_item;

    typedef struct packed {
        t_ctrl_state           ctrl_state;
        t_err                  last_error;
        logic [BYTE_W-1:0]     target_addr;
        logic [LEN_W-1:0]      bytes_left;
        logic                  irq_on;
    } t_ctx;

    typedef struct packed {
        logic                  accepted;
        logic                  dr_write_valid;
        logic [BYTE_W-1:0]     dr_write_value;
        logic                  gen_start;
        logic                  gen_stop;
        t_ack                  ack_control;
        logic                  rx_valid;
        logic [BYTE_W-1:0]     rx_data;
        logic                  rx_last;
        logic                  irq_enabled;
        t_ctrl_state           state_code;
        t_err                  error_code;
    } t_result;

endpackage

`default_nettype wire

### design/i2cmes_decode.sv
`default_nettype none

module i2cmes_decode (
    input  wire i2cmes_pkg::t_item   i_item,
    input  wire i2cmes_pkg::t_ctx    i_ctx,
    output i2cmes_pkg::t_ctx         o_ctx,
    output i2cmes_pkg::t_result      o_res
);

    logic                                 left_nz;
    logic                                 left_one;
    logic                                 left_two;
    logic [i2cmes_pkg::LEN_W-1:0]         left_dec;
    logic [i2cmes_pkg::STATUS_W-1:0]      st;

    assign st       = i_item.status;
    assign left_nz  = (i_ctx.bytes_left != '0);
    assign left_one = (i_ctx.bytes_left == i2cmes_pkg::LEN_W'(1));
    assign left_two = (i_ctx.bytes_left == i2cmes_pkg::LEN_W'(2));
    // Count saturates at zero
    assign left_dec = left_nz ? (i_ctx.bytes_left - i2cmes_pkg::LEN_W'(1)) : i_ctx.bytes_left;

    always_comb begin
        o_ctx = i_ctx;
        o_res = '0;

        unique case (i_item.req_type)
            i2cmes_pkg::REQ_WRITE, i2cmes_pkg::REQ_READ: begin
                if (i_ctx.ctrl_state == i2cmes_pkg::ST_READY) begin
                    if (i_item.bus_busy) begin
                        o_ctx.last_error = i2cmes_pkg::ERR_BUSY;
                    end else begin
                        o_ctx.ctrl_state  = (i_item.req_type == i2cmes_pkg::REQ_READ)
                                            ? i2cmes_pkg::ST_RX : i2cmes_pkg::ST_TX;
                        o_ctx.last_error  = i2cmes_pkg::ERR_NONE;
                        o_ctx.target_addr = i_item.dev_addr;
                        o_ctx.bytes_left  = i_item.xfer_len;
                        o_ctx.irq_on      = 1'b1;
                        o_res.ack_control = (i_item.req_type == i2cmes_pkg::REQ_READ)
                                            ? i2cmes_pkg::ACK_ON : i2cmes_pkg::ACK_KEEP;
                        o_res.gen_start   = 1'b1;
                        o_res.accepted    = 1'b1;
                    end
                end
            end

            i2cmes_pkg::REQ_EVENT: begin
                o_res.accepted = 1'b1;
                if (st[i2cmes_pkg::F_SB]) begin
                    if (i_ctx.ctrl_state == i2cmes_pkg::ST_TX) begin
                        o_res.dr_write_valid = 1'b1;
                        o_res.dr_write_value = {i_ctx.target_addr[i2cmes_pkg::BYTE_W-1:1],
                                                i2cmes_pkg::DIR_WRITE};
                    end else if (i_ctx.ctrl_state == i2cmes_pkg::ST_RX) begin
                        o_res.dr_write_valid = 1'b1;
                        o_res.dr_write_value = {i_ctx.target_addr[i2cmes_pkg::BYTE_W-1:1],
                                                i2cmes_pkg::DIR_READ};
                    end else begin
                        o_ctx.ctrl_state = i2cmes_pkg::ST_ERROR;
                        o_ctx.last_error = i2cmes_pkg::ERR_SB;
                    end
                end else if (st[i2cmes_pkg::F_ADDR]) begin
                    // Single-byte read: NACK and stop right after the address phase
                    if (i_ctx.ctrl_state == i2cmes_pkg::ST_RX && left_one) begin
                        o_res.ack_control = i2cmes_pkg::ACK_OFF;
                        o_res.gen_stop    = 1'b1;
                    end
                end else if (st[i2cmes_pkg::F_TXE] && !st[i2cmes_pkg::F_BTF] &&
                             i_ctx.ctrl_state == i2cmes_pkg::ST_TX) begin
                    if (left_nz) begin
                        o_res.dr_write_valid = 1'b1;
                        o_res.dr_write_value = i_item.tx_byte;
                        o_ctx.bytes_left     = left_dec;
                    end
                end else if (st[i2cmes_pkg::F_BTF]) begin
                    if (i_ctx.ctrl_state == i2cmes_pkg::ST_TX) begin
                        if (left_nz) begin
                            o_res.dr_write_valid = 1'b1;
                            o_res.dr_write_value = i_item.tx_byte;
                            o_ctx.bytes_left     = left_dec;
                        end else begin
                            o_res.gen_stop   = 1'b1;
                            o_ctx.irq_on     = 1'b0;
                            o_ctx.ctrl_state = i2cmes_pkg::ST_READY;
                        end
                    end
                end else if (st[i2cmes_pkg::F_RXNE]) begin
                    if (i_ctx.ctrl_state == i2cmes_pkg::ST_RX) begin
                        o_res.rx_valid   = 1'b1;
                        o_res.rx_data    = i_item.rx_byte;
                        o_ctx.bytes_left = left_dec;
                        if (left_nz && !left_one) begin
                            if (left_two) begin
                                o_res.ack_control = i2cmes_pkg::ACK_OFF;
                                o_res.gen_stop    = 1'b1;
                            end
                        end else begin
                            o_res.rx_last    = 1'b1;
                            o_ctx.ctrl_state = i2cmes_pkg::ST_READY;
                            o_ctx.irq_on     = 1'b0;
                        end
                    end
                end
            end

            i2cmes_pkg::REQ_ERROR: begin
                o_res.accepted = 1'b1;
                if (st[i2cmes_pkg::F_AF]) begin
                    o_res.gen_stop   = 1'b1;
                    o_ctx.ctrl_state = i2cmes_pkg::ST_ERROR;
                    o_ctx.last_error = i2cmes_pkg::ERR_AF;
                end else if (st[i2cmes_pkg::F_BERR]) begin
                    o_ctx.ctrl_state = i2cmes_pkg::ST_ERROR;
                    o_ctx.last_error = i2cmes_pkg::ERR_BUS;
                end else if (st[i2cmes_pkg::F_ARLO]) begin
                    o_ctx.ctrl_state = i2cmes_pkg::ST_ERROR;
                    o_ctx.last_error = i2cmes_pkg::ERR_ARLO;
                end else if (st[i2cmes_pkg::F_OVR]) begin
                    o_ctx.ctrl_state = i2cmes_pkg::ST_ERROR;
                    o_ctx.last_error = i2cmes_pkg::ERR_OVR;
                end
                o_ctx.irq_on = 1'b0;
            end

            default: begin
                o_ctx = i_ctx;
            end
        endcase

        o_res.irq_enabled = o_ctx.irq_on;
        o_res.state_code  = o_ctx.ctrl_state;
        o_res.error_code  = o_ctx.last_error;
    end

endmodule

`default_nettype wire

### design/i2c_master_event_sequencer.sv
// Channel   Direction  Handshake                  Payload
// in        sink       i_in_valid / o_in_ready    i_req_type .. i_rx_byte
// out       source     o_out_valid / i_out_ready  o_accepted .. o_error_code
//
// Each item passes an input register, one pass of decode logic and a result
// register; one item per cycle sustained while the receiver takes each result.
// The transfer context (state, error, address, count, irq enable) updates in
// the same cycle the item moves from the input register into the result register.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// context to ready with no error, zero count and interrupts disabled.
// A stalled result holds the decode stage; the input register then fills and
// o_in_ready drops until the result is taken.
`default_nettype none

module i2c_master_event_sequencer (
    input  wire          i_clk,
    input  wire          i_rst_n,

    input  wire          i_in_valid,
    output logic         o_in_ready,
    input  wire  [1:0]   i_req_type,
    input  wire  [7:0]   i_dev_addr,
    input  wire  [15:0]  i_xfer_len,
    input  wire          i_bus_busy,
    input  wire  [11:0]  i_status,
    input  wire  [7:0]   i_tx_byte,
    input  wire  [7:0]   i_rx_byte,

    output logic         o_out_valid,
    input  wire          i_out_ready,
    output logic         o_accepted,
    output logic         o_dr_write_valid,
    output logic [7:0]   o_dr_write_value,
    output logic         o_gen_start,
    output logic         o_gen_stop,
    output logic [1:0]   o_ack_control,
    output logic         o_rx_valid,
    output logic [7:0]   o_rx_data,
    output logic         o_rx_last,
    output logic         o_irq_enabled,
    output logic [1:0]   o_state_code,
    output logic [2:0]   o_error_code
);

    logic                   r_in_valid;
    i2cmes_pkg::t_item      r_item;
    logic                   r_out_valid;
    i2cmes_pkg::t_result    r_res;
    i2cmes_pkg::t_ctx       r_ctx;

    i2cmes_pkg::t_ctx       n_ctx;
    i2cmes_pkg::t_result    n_res;
    logic                   advance;

    // Move an item into the result register when the result slot is free or drains now
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.req_type <= i2cmes_pkg::t_req'(i_req_type);
            r_item.dev_addr <= i_dev_addr;
            r_item.xfer_len <= i_xfer_len;
            r_item.bus_busy <= i_bus_busy;
            r_item.status   <= i_status;
            r_item.tx_byte  <= i_tx_byte;
            r_item.rx_byte  <= i_rx_byte;
        end
    end

    i2cmes_decode u_decode (
        .i_item (r_item),
        .i_ctx  (r_ctx),
        .o_ctx  (n_ctx),
        .o_res  (n_res)
    );

    // Context register: advance only with an item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.ctrl_state  <= i2cmes_pkg::ST_READY;
            r_ctx.last_error  <= i2cmes_pkg::ERR_NONE;
            r_ctx.target_addr <= '0;
            r_ctx.bytes_left  <= '0;
            r_ctx.irq_on      <= 1'b0;
        end else if (advance) begin
            r_ctx <= n_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_res.accepted;
    assign o_dr_write_valid = r_res.dr_write_valid;
    assign o_dr_write_value = r_res.dr_write_value;
    assign o_gen_start      = r_res.gen_start;
    assign o_gen_stop       = r_res.gen_stop;
    assign o_ack_control    = r_res.ack_control;
    assign o_rx_valid       = r_res.rx_valid;
    assign o_rx_data        = r_res.rx_data;
    assign o_rx_last        = r_res.rx_last;
    assign o_irq_enabled    = r_res.irq_enabled;
    assign o_state_code     = r_res.state_code;
    assign o_error_code     = r_res.error_code;

    // Error state is sticky until reset
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctx.ctrl_state == i2cmes_pkg::ST_ERROR |=> r_ctx.ctrl_state == i2cmes_pkg::ST_ERROR)
        else $error("error state left without reset");

    // A decoded item always lands in the result register
    a_advance_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced item lost");

    // Last received byte closes the transfer
    a_rx_last_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rx_last) |-> (o_state_code == i2cmes_pkg::ST_READY && !o_irq_enabled))
        else $error("last byte without return to ready");

    // A start condition only comes with an accepted request
    a_start_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_gen_start) |-> (o_accepted && o_irq_enabled))
        else $error("start without accepted request");

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import i2cmes_pkg::*;

    // Error flags of the status word; event items ignore them, error items act on them
    localparam logic [STATUS_W-1:0] ERROR_FLAG_MASK =
        STATUS_W'((1 << F_BERR) | (1 << F_ARLO) | (1 << F_AF) | (1 << F_OVR));

    localparam int RANDOM_ITEMS = 1800;

    // Mirror of the transfer context plus the queue of results still owed by the block
    class xfer_scoreboard;
        t_ctx    ctx;
        t_result expected_q[$];
        int      errors;
        int      n_checked;

        function new();
            ctx.ctrl_state  = ST_READY;
            ctx.last_error  = ERR_NONE;
            ctx.target_addr = '0;
            ctx.bytes_left  = '0;
            ctx.irq_on      = 1'b0;
            errors          = 0;
            n_checked       = 0;
        endfunction

        // Work out the result of one item and advance the context
        function t_result decode_item(t_item it);
            t_result r;
            r = '0;
            case (it.req_type)
                REQ_WRITE, REQ_READ: begin
                    if (ctx.ctrl_state == ST_READY) begin
                        if (it.bus_busy) begin
                            ctx.last_error = ERR_BUSY;
                        end else begin
                            if (it.req_type == REQ_WRITE) begin
                                ctx.ctrl_state = ST_TX;
                            end else begin
                                ctx.ctrl_state = ST_RX;
                                r.ack_control  = ACK_ON;
                            end
                            ctx.last_error  = ERR_NONE;
                            ctx.target_addr = it.dev_addr;
                            ctx.bytes_left  = it.xfer_len;
                            ctx.irq_on      = 1'b1;
                            r.gen_start     = 1'b1;
                            r.accepted      = 1'b1;
                        end
                    end
                end
                REQ_EVENT: begin
                    r.accepted = 1'b1;
                    if (it.status[F_SB]) begin
                        if (ctx.ctrl_state == ST_TX) begin
                            r.dr_write_valid = 1'b1;
                            r.dr_write_value = {ctx.target_addr[7:1], DIR_WRITE};
                        end else if (ctx.ctrl_state == ST_RX) begin
                            r.dr_write_valid = 1'b1;
                            r.dr_write_value = {ctx.target_addr[7:1], DIR_READ};
                        end else begin
                            ctx.ctrl_state = ST_ERROR;
                            ctx.last_error = ERR_SB;
                        end
                    end else if (it.status[F_ADDR]) begin
                        if (ctx.ctrl_state == ST_RX && ctx.bytes_left == 1) begin
                            r.ack_control = ACK_OFF;
                            r.gen_stop    = 1'b1;
                        end
                    end else if (it.status[F_TXE] && !it.status[F_BTF] &&
                                 ctx.ctrl_state == ST_TX) begin
                        if (ctx.bytes_left != 0) begin
                            r.dr_write_valid = 1'b1;
                            r.dr_write_value = it.tx_byte;
                            ctx.bytes_left   = ctx.bytes_left - 1'b1;
                        end
                    end else if (it.status[F_BTF]) begin
                        if (ctx.ctrl_state == ST_TX) begin
                            if (ctx.bytes_left != 0) begin
                                r.dr_write_valid = 1'b1;
                                r.dr_write_value = it.tx_byte;
                                ctx.bytes_left   = ctx.bytes_left - 1'b1;
                            end else begin
                                r.gen_stop     = 1'b1;
                                ctx.irq_on     = 1'b0;
                                ctx.ctrl_state = ST_READY;
                            end
                        end
                    end else if (it.status[F_RXNE]) begin
                        if (ctx.ctrl_state == ST_RX) begin
                            r.rx_valid = 1'b1;
                            r.rx_data  = it.rx_byte;
                            if (ctx.bytes_left > 1) begin
                                if (ctx.bytes_left == 2) begin
                                    r.ack_control = ACK_OFF;
                                    r.gen_stop    = 1'b1;
                                end
                                ctx.bytes_left = ctx.bytes_left - 1'b1;
                            end else begin
                                // A zero count stays at zero
                                if (ctx.bytes_left != 0)
                                    ctx.bytes_left = ctx.bytes_left - 1'b1;
                                r.rx_last      = 1'b1;
                                ctx.ctrl_state = ST_READY;
                                ctx.irq_on     = 1'b0;
                            end
                        end
                    end
                end
                default: begin
                    r.accepted = 1'b1;
                    if (it.status[F_AF]) begin
                        r.gen_stop     = 1'b1;
                        ctx.ctrl_state = ST_ERROR;
                        ctx.last_error = ERR_AF;
                    end else if (it.status[F_BERR]) begin
                        ctx.ctrl_state = ST_ERROR;
                        ctx.last_error = ERR_BUS;
                    end else if (it.status[F_ARLO]) begin
                        ctx.ctrl_state = ST_ERROR;
                        ctx.last_error = ERR_ARLO;
                    end else if (it.status[F_OVR]) begin
                        ctx.ctrl_state = ST_ERROR;
                        ctx.last_error = ERR_OVR;
                    end
                    ctx.irq_on = 1'b0;
                end
            endcase
            r.irq_enabled = ctx.irq_on;
            r.state_code  = ctx.ctrl_state;
            r.error_code  = ctx.last_error;
            return r;
        endfunction

        function void note_item(t_item it);
            expected_q.push_back(decode_item(it));
        endfunction

        function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (act_v !== exp_v) begin
                errors++;
                $display("%0t: result %0d %s expected %0h actual %0h",
                         $time, n_checked, name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %0h",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            cmp_field("accepted",       8'(want.accepted),       8'(got.accepted));
            cmp_field("dr_write_valid", 8'(want.dr_write_valid), 8'(got.dr_write_valid));
            cmp_field("dr_write_value", want.dr_write_value,     got.dr_write_value);
            cmp_field("gen_start",      8'(want.gen_start),      8'(got.gen_start));
            cmp_field("gen_stop",       8'(want.gen_stop),       8'(got.gen_stop));
            cmp_field("ack_control",    8'(want.ack_control),    8'(got.ack_control));
            cmp_field("rx_valid",       8'(want.rx_valid),       8'(got.rx_valid));
            cmp_field("rx_data",        want.rx_data,            got.rx_data);
            cmp_field("rx_last",        8'(want.rx_last),        8'(got.rx_last));
            cmp_field("irq_enabled",    8'(want.irq_enabled),    8'(got.irq_enabled));
            cmp_field("state_code",     8'(want.state_code),     8'(got.state_code));
            cmp_field("error_code",     8'(want.error_code),     8'(got.error_code));
            n_checked++;
        endfunction
    endclass

    // Block inputs start at known values; the stimulus moves them at rising edges only
    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic [1:0]    i_req_type  = '0;
    logic [7:0]    i_dev_addr  = '0;
    logic [15:0]   i_xfer_len  = '0;
    logic          i_bus_busy  = 1'b0;
    logic [11:0]   i_status    = '0;
    logic [7:0]    i_tx_byte   = '0;
    logic [7:0]    i_rx_byte   = '0;
    logic          i_out_ready = 1'b0;

    logic          o_in_ready;
    logic          o_out_valid;
    logic          o_accepted;
    logic          o_dr_write_valid;
    logic [7:0]    o_dr_write_value;
    logic          o_gen_start;
    logic          o_gen_stop;
    logic [1:0]    o_ack_control;
    logic          o_rx_valid;
    logic [7:0]    o_rx_data;
    logic          o_rx_last;
    logic          o_irq_enabled;
    logic [1:0]    o_state_code;
    logic [2:0]    o_error_code;

    xfer_scoreboard sb = new();

    // Full-speed window: no gaps from the sender, receiver always ready
    bit full_speed = 1'b0;
    int ready_hold = 0;

    i2c_master_event_sequencer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_dev_addr       (i_dev_addr),
        .i_xfer_len       (i_xfer_len),
        .i_bus_busy       (i_bus_busy),
        .i_status         (i_status),
        .i_tx_byte        (i_tx_byte),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_accepted       (o_accepted),
        .o_dr_write_valid (o_dr_write_valid),
        .o_dr_write_value (o_dr_write_value),
        .o_gen_start      (o_gen_start),
        .o_gen_stop       (o_gen_stop),
        .o_ack_control    (o_ack_control),
        .o_rx_valid       (o_rx_valid),
        .o_rx_data        (o_rx_data),
        .o_rx_last        (o_rx_last),
        .o_irq_enabled    (o_irq_enabled),
        .o_state_code     (o_state_code),
        .o_error_code     (o_error_code)
    );

    always #2 i_clk = ~i_clk;

    // Receiver: hold ready high or low for random stretches, mostly short stalls
    always @(posedge i_clk) begin
        int pick;
        if (full_speed) begin
            i_out_ready <= 1'b1;
            ready_hold  <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                i_out_ready <= 1'b1;
                ready_hold  <= $urandom_range(0, 15);
            end else if (pick < 95) begin
                i_out_ready <= 1'b0;
                ready_hold  <= $urandom_range(0, 2);
            end else begin
                i_out_ready <= 1'b0;
                ready_hold  <= $urandom_range(8, 30);
            end
        end
    end

    // Take every result the block hands over and compare it with the oldest prediction
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = t_result'({o_accepted, o_dr_write_valid, o_dr_write_value,
                             o_gen_start, o_gen_stop, o_ack_control,
                             o_rx_valid, o_rx_data, o_rx_last,
                             o_irq_enabled, o_state_code, o_error_code});
            sb.check_result(got);
        end
    end

    function automatic t_item make_item(t_req rq, logic [7:0] addr, logic [15:0] len,
                                        logic busy, logic [11:0] st,
                                        logic [7:0] txb, logic [7:0] rxb);
        t_item it;
        it.req_type = rq;
        it.dev_addr = addr;
        it.xfer_len = len;
        it.bus_busy = busy;
        it.status   = st;
        it.tx_byte  = txb;
        it.rx_byte  = rxb;
        return it;
    endfunction

    function automatic logic [11:0] flag(int unsigned pos);
        return 12'(1 << pos);
    endfunction

    // Sender gap: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (full_speed || pick < 55)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 40);
    endfunction

    // Random item shaped by the predicted state, so transfers run to completion.
    // Never raise the start flag outside a transfer and never set an error flag
    // on an error item here: either would lock the block in the error state.
    function automatic t_item next_random_item();
        t_item       it;
        int          roll;
        t_ctrl_state cur;
        cur         = sb.ctx.ctrl_state;
        roll        = $urandom_range(0, 99);
        it.dev_addr = 8'($urandom_range(0, 255));
        it.xfer_len = 16'($urandom_range(0, 65535));
        it.bus_busy = ($urandom_range(0, 9) == 0);
        it.status   = 12'($urandom_range(0, 4095));
        it.tx_byte  = 8'($urandom_range(0, 255));
        it.rx_byte  = 8'($urandom_range(0, 255));
        if (cur == ST_READY) begin
            if (roll < 80) begin
                it.req_type = $urandom_range(0, 1) ? REQ_READ : REQ_WRITE;
                // Mostly short transfers; a rare one crosses into the upper count byte
                if (!it.bus_busy) begin
                    if ($urandom_range(0, 99) == 0)
                        it.xfer_len = 16'h0100 + 16'($urandom_range(0, 3));
                    else
                        it.xfer_len = 16'($urandom_range(0, 6));
                end
            end else if (roll < 92) begin
                it.req_type       = REQ_EVENT;
                it.status[F_SB]   = 1'b0;
            end else begin
                it.req_type = REQ_ERROR;
                it.status   = it.status & ~ERROR_FLAG_MASK;
            end
        end else if (cur == ST_TX || cur == ST_RX) begin
            if (roll < 6) begin
                it.req_type = $urandom_range(0, 1) ? REQ_READ : REQ_WRITE;
            end else if (roll < 10) begin
                it.req_type = REQ_ERROR;
                it.status   = it.status & ~ERROR_FLAG_MASK;
            end else begin
                it.req_type         = REQ_EVENT;
                it.status[F_SB]     = ($urandom_range(0, 7) == 0);
                it.status[F_ADDR]   = ($urandom_range(0, 3) == 0);
                if (cur == ST_RX) begin
                    it.status[F_BTF]  = ($urandom_range(0, 3) == 0);
                    it.status[F_RXNE] = ($urandom_range(0, 3) != 0);
                end
            end
        end else begin
            it.req_type     = REQ_EVENT;
            it.status[F_SB] = 1'b0;
        end
        return it;
    endfunction

    // Present one item and hold it until the block takes it
    task automatic drive_item(input t_item it, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= it.req_type;
        i_dev_addr <= it.dev_addr;
        i_xfer_len <= it.xfer_len;
        i_bus_busy <= it.bus_busy;
        i_status   <= it.status;
        i_tx_byte  <= it.tx_byte;
        i_rx_byte  <= it.rx_byte;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(it);
    endtask

    task automatic drive_event(input logic [11:0] st, input logic [7:0] txb,
                               input logic [7:0] rxb);
        drive_item(make_item(REQ_EVENT, 8'h00, 16'h0000, 1'b0, st, txb, rxb), pick_gap());
    endtask

    task automatic drive_request(input t_req rq, input logic [7:0] addr,
                                 input logic [15:0] len, input logic busy);
        drive_item(make_item(rq, addr, len, busy, 12'h000, 8'h00, 8'h00), pick_gap());
    endtask

    task automatic drive_error(input logic [11:0] st);
        drive_item(make_item(REQ_ERROR, 8'h00, 16'h0000, 1'b0, st, 8'h00, 8'h00),
                   pick_gap());
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Idle block: empty event and an error item with no error flag
        drive_event(12'h000, 8'h00, 8'h00);
        drive_error(12'h000);
        // Busy bus rejects the request and records the busy error
        drive_request(REQ_WRITE, 8'hFF, 16'hFFFF, 1'b1);

        // Write of two bytes; a second request during the transfer is rejected
        drive_request(REQ_WRITE, 8'hA5, 16'd2, 1'b0);
        drive_request(REQ_READ, 8'h00, 16'd0, 1'b0);
        drive_event(flag(F_SB), 8'h00, 8'h00);
        drive_event(flag(F_ADDR), 8'h00, 8'h00);
        drive_event(flag(F_TXE), 8'h00, 8'h00);
        drive_event(flag(F_TXE) | flag(F_BTF), 8'hFF, 8'h00);
        drive_event(flag(F_BTF), 8'h00, 8'h00);

        // Single-byte read: ACK off and stop on the address phase
        drive_request(REQ_READ, 8'h5A, 16'd1, 1'b0);
        drive_event(flag(F_SB), 8'h00, 8'h00);
        drive_event(flag(F_ADDR), 8'h00, 8'h00);
        drive_event(flag(F_RXNE), 8'h00, 8'hFF);

        // Read with a zero count: the byte still arrives as the last one
        drive_request(REQ_READ, 8'h00, 16'd0, 1'b0);
        drive_event(flag(F_SB), 8'h00, 8'h00);
        drive_event(flag(F_RXNE), 8'h00, 8'h00);

        // Three-byte read: ACK off and stop with two bytes left
        drive_request(REQ_READ, 8'hFF, 16'd3, 1'b0);
        drive_event(flag(F_SB), 8'h00, 8'h00);
        drive_event(flag(F_ADDR), 8'h00, 8'h00);
        drive_event(flag(F_RXNE), 8'h00, 8'h11);
        drive_event(flag(F_RXNE), 8'h00, 8'h22);
        drive_event(flag(F_RXNE), 8'h00, 8'h33);

        // Random traffic with a full-speed window and one full drain
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 150)
                full_speed <= 1'b1;
            if (n == 400)
                full_speed <= 1'b0;
            if (n == 900) begin
                i_in_valid <= 1'b0;
                while (sb.expected_q.size() != 0) @(posedge i_clk);
            end
            drive_item(next_random_item(), pick_gap());
        end

        // Finish the open transfer so the closing checks start from ready
        while (sb.ctx.ctrl_state == ST_TX || sb.ctx.ctrl_state == ST_RX) begin
            if (sb.ctx.ctrl_state == ST_TX)
                drive_event(flag(F_BTF), 8'($urandom_range(0, 255)), 8'h00);
            else
                drive_event(flag(F_RXNE), 8'h00, 8'($urandom_range(0, 255)));
        end

        // Full-count read, then the error paths; the error state is final
        drive_request(REQ_READ, 8'hFE, 16'hFFFF, 1'b0);
        drive_event(flag(F_SB), 8'h00, 8'h00);
        drive_event(flag(F_ADDR), 8'h00, 8'h00);
        drive_event(flag(F_RXNE), 8'h00, 8'h3C);
        drive_event(flag(F_RXNE), 8'h00, 8'hC3);
        drive_error(12'hFFF);
        drive_request(REQ_WRITE, 8'h42, 16'd1, 1'b0);
        drive_error(flag(F_BERR) | flag(F_ARLO) | flag(F_OVR));
        drive_error(flag(F_ARLO) | flag(F_OVR));
        drive_error(flag(F_OVR));
        // Start flag outside a transfer
        drive_event(flag(F_SB), 8'h00, 8'h00);
        drive_error(12'h000);
        drive_request(REQ_READ, 8'h42, 16'd1, 1'b0);

        // Drop valid, wait out the last results and let stray ones show up
        i_in_valid <= 1'b0;
        full_speed <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog well past the slowest legal run
    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
design/i2cmes_pkg.sv
design/i2cmes_decode.sv
design/i2c_master_event_sequencer.sv
sim/tb_top.sv
